@@ rtl/vector_angle_atan2_core_assert.svh @@
// Assertion macros for the checker of the angle core.
`ifndef VECTOR_ANGLE_ATAN2_CORE_ASSERT_SVH
`define VECTOR_ANGLE_ATAN2_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define VAA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Implication with a fixed delay in cycles.
`define VAA_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/vaa_pkg.sv @@
`default_nettype none
package vaa_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int ANGLE_W      = 16;
    localparam int PRE_SHIFT    = 28;
    localparam int GUARD_W      = 3;
    localparam int XY_W         = GUARD_W + COORD_WIDTH + PRE_SHIFT;
    localparam int Z_W          = 32;
    localparam int TABLE_LEN    = 30;
    localparam int ATAN_IDX_W   = $clog2(TABLE_LEN);
    localparam int ROUND_SHIFT  = 17;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COORD_WIDTH-1:0] COORD_ONE    = COORD_WIDTH'(1);
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30  = 32'sd1686629713;
    localparam logic signed [Z_W-1:0]  ROUND_BIAS   = 32'sd65536;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] dx;
        logic signed [COORD_WIDTH-1:0] dy;
    } vaa_req_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      undefined_angle;
    } vaa_res_t;

    // Quadrant and degenerate-axis flags decided by the front end.
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic x_zero;
        logic y_zero;
    } vaa_tag_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] mag_x;
        logic [COORD_WIDTH-1:0] mag_y;
        vaa_tag_t               tag;
    } vaa_item_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        vaa_tag_t               tag;
    } vaa_cordic_t;

    // atan(2^-i) in Q.30, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'sd843314857;
            5'd1:  v = 32'sd497837830;
            5'd2:  v = 32'sd263043837;
            5'd3:  v = 32'sd133525159;
            5'd4:  v = 32'sd67021687;
            5'd5:  v = 32'sd33543516;
            5'd6:  v = 32'sd16775851;
            5'd7:  v = 32'sd8388437;
            5'd8:  v = 32'sd4194283;
            5'd9:  v = 32'sd2097149;
            5'd10: v = 32'sd1048576;
            5'd11: v = 32'sd524288;
            5'd12: v = 32'sd262144;
            5'd13: v = 32'sd131072;
            5'd14: v = 32'sd65536;
            5'd15: v = 32'sd32768;
            5'd16: v = 32'sd16384;
            5'd17: v = 32'sd8192;
            5'd18: v = 32'sd4096;
            5'd19: v = 32'sd2048;
            5'd20: v = 32'sd1024;
            5'd21: v = 32'sd512;
            5'd22: v = 32'sd256;
            5'd23: v = 32'sd128;
            5'd24: v = 32'sd64;
            5'd25: v = 32'sd32;
            5'd26: v = 32'sd16;
            5'd27: v = 32'sd8;
            5'd28: v = 32'sd4;
            5'd29: v = 32'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/vaa_front.sv @@
`default_nettype none
module vaa_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vaa_pkg::vaa_req_t req,
    input  wire logic              q_full,
    output logic                   push,
    output vaa_pkg::vaa_item_t     item
);
    import vaa_pkg::*;

    logic                   valid_reg, valid_next;
    vaa_item_t              item_reg, item_next;
    logic                   accept;
    logic [COORD_WIDTH-1:0] dx_u, dy_u;

    assign busy   = valid_reg & q_full;
    assign push   = valid_reg & ~q_full;
    assign accept = start & ~busy;
    assign item   = item_reg;

    assign dx_u = req.dx;
    assign dy_u = req.dy;

    // Classify: signs, axis hits, magnitudes (the most negative value maps to 2^(W-1)).
    always_comb
    begin
        item_next.tag.xneg   = dx_u[COORD_WIDTH-1];
        item_next.tag.yneg   = dy_u[COORD_WIDTH-1];
        item_next.tag.x_zero = (dx_u == '0);
        item_next.tag.y_zero = (dy_u == '0);
        item_next.mag_x      = dx_u[COORD_WIDTH-1] ? (~dx_u + COORD_ONE) : dx_u;
        item_next.mag_y      = dy_u[COORD_WIDTH-1] ? (~dy_u + COORD_ONE) : dy_u;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vaa_queue.sv @@
`default_nettype none
module vaa_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire vaa_pkg::vaa_item_t wdata,
    output logic                    full,
    output logic                    valid,
    input  wire logic               pop,
    output vaa_pkg::vaa_item_t      rdata
);
    import vaa_pkg::*;

    vaa_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign do_pop = pop & valid;
    assign rdata  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, do_pop})
            2'b10:   count_next = QCNT_W'(count_reg + 1'b1);
            2'b01:   count_next = QCNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vaa_back.sv @@
`default_nettype none
module vaa_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire vaa_pkg::vaa_item_t in_item,
    output logic                    pop,
    output logic                    done,
    output vaa_pkg::vaa_res_t       result
);
    import vaa_pkg::*;

    // One vectoring iteration: drive y toward zero, collect the rotation in z.
    function automatic vaa_cordic_t cordic_step(input vaa_cordic_t s, input int idx);
        vaa_cordic_t            r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = s.x;
        ys = s.y;
        xs = xs >>> idx;
        ys = ys >>> idx;
        r  = s;
        if (!s.y[XY_W-1])
        begin
            r.x = s.x + ys;
            r.y = s.y - xs;
            r.z = s.z + atan_q30(ATAN_IDX_W'(idx));
        end
        else
        begin
            r.x = s.x - ys;
            r.y = s.y + xs;
            r.z = s.z - atan_q30(ATAN_IDX_W'(idx));
        end
        return r;
    endfunction

    logic [CORDIC_STEPS:0]     sv_reg;
    vaa_cordic_t               st_reg [CORDIC_STEPS+1];
    vaa_cordic_t               step_next [CORDIC_STEPS];
    vaa_cordic_t               init_next;

    logic                      rv_reg;
    logic signed [ANGLE_W-1:0] a_reg, a_next;
    vaa_tag_t                  atag_reg;

    logic                      done_reg;
    vaa_res_t                  res_reg, res_next;

    logic signed [Z_W-1:0]             zc;
    logic signed [Z_W-1:0]             zr;
    logic [Z_W-ROUND_SHIFT-1:0]        qv;
    logic signed [ANGLE_W-1:0]         qa;

    vaa_cordic_t last;

    // The back end never stalls: drain the queue whenever it holds a beat.
    assign pop    = in_valid;
    assign done   = done_reg;
    assign result = res_reg;
    assign last   = st_reg[CORDIC_STEPS];

    always_comb
    begin
        init_next.x   = $signed({{GUARD_W{1'b0}}, in_item.mag_x, {PRE_SHIFT{1'b0}}});
        init_next.y   = $signed({{GUARD_W{1'b0}}, in_item.mag_y, {PRE_SHIFT{1'b0}}});
        init_next.z   = '0;
        init_next.tag = in_item.tag;
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++)
    begin : g_step
        assign step_next[gi] = cordic_step(st_reg[gi], gi);
    end

    // Clamp z to [0, pi/2], round half up to Q3.13, then resolve the axis cases.
    always_comb
    begin
        if (last.z < 0)
        begin
            zc = '0;
        end
        else if (last.z > HALF_PI_Q30)
        begin
            zc = HALF_PI_Q30;
        end
        else
        begin
            zc = last.z;
        end
        zr = zc + ROUND_BIAS;
        qv = zr[Z_W-1:ROUND_SHIFT];
        qa = $signed({{(ANGLE_W-Z_W+ROUND_SHIFT){1'b0}}, qv});
        if (last.tag.x_zero)
        begin
            a_next = HALF_PI_Q13;
        end
        else if (last.tag.y_zero)
        begin
            a_next = '0;
        end
        else if (qa > HALF_PI_Q13)
        begin
            a_next = HALF_PI_Q13;
        end
        else
        begin
            a_next = qa;
        end
    end

    // Fold the first-quadrant angle into the vector's quadrant.
    always_comb
    begin
        res_next.undefined_angle = atag_reg.x_zero & atag_reg.y_zero;
        if (atag_reg.x_zero && atag_reg.y_zero)
        begin
            res_next.angle = '0;
        end
        else if (atag_reg.yneg && !atag_reg.xneg)
        begin
            res_next.angle = -a_reg;
        end
        else if (atag_reg.yneg && atag_reg.xneg)
        begin
            res_next.angle = a_reg - PI_Q13;
        end
        else if (atag_reg.xneg)
        begin
            res_next.angle = PI_Q13 - a_reg;
        end
        else
        begin
            res_next.angle = a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg   <= '0;
            rv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sv_reg   <= {sv_reg[CORDIC_STEPS-1:0], in_valid};
            rv_reg   <= sv_reg[CORDIC_STEPS];
            done_reg <= rv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= init_next;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            st_reg[k+1] <= step_next[k];
        end
        a_reg    <= a_next;
        atag_reg <= last.tag;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire

@@ rtl/vector_angle_atan2_core.sv @@
`default_nettype none
// Four-quadrant arctangent of a signed 2-D vector (dx, dy), returned as radians
// in signed Q3.13 over [-pi, pi], with pi = 25736. Raise start with a vector on
// req; the beat is taken at any rising edge where start is high and busy is low.
// A new vector can be taken every cycle while busy is low. Each beat yields
// exactly one result, shown on result for a single cycle with done high. The
// result passes, in order, through the classify register, the queue, the
// CORDIC pipeline (a load stage plus one stage per vectoring step), the round
// stage and the output register.
// The receiver cannot stall: capture result in the cycle done is high, or it
// is lost. A zero vector gives angle 0 with undefined_angle set; a vector on
// the y axis gives exactly +/-pi/2, and one on the negative x axis gives pi.
// busy rises only when the queue between front and back end is full.
module vector_angle_atan2_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vaa_pkg::vaa_req_t req,
    output logic                   done,
    output vaa_pkg::vaa_res_t      result
);
    import vaa_pkg::*;

    // Front end to queue.
    logic      push;
    logic      q_full;
    vaa_item_t f_item;

    // Queue to back end.
    logic      q_valid;
    logic      pop;
    vaa_item_t q_item;

    // Classify the beat: signs, axis hits and magnitudes.
    vaa_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .item   (f_item)
    );

    // Decouple classification from the CORDIC pipeline.
    vaa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_item),
        .full  (q_full),
        .valid (q_valid),
        .pop   (pop),
        .rdata (q_item)
    );

    // Run the vectoring pipeline, round and fold into the quadrant.
    vaa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

endmodule
`default_nettype wire

@@ rtl/vaa_checker.sv @@
`default_nettype none
`include "vector_angle_atan2_core_assert.svh"
module vaa_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire vaa_pkg::vaa_req_t req,
    input wire logic              done,
    input wire vaa_pkg::vaa_res_t result
);
    import vaa_pkg::*;

    localparam int RESULT_LATENCY = CORDIC_STEPS + 5;

    logic zero_vec;
    logic flag_got;

    assign zero_vec = (req.dx == '0) && (req.dy == '0);
    assign flag_got = result.undefined_angle;

    // Every accepted beat comes back after a fixed latency, and nothing else does.
    `VAA_ASSERT_DELAY(a_accept_done, clk, rst_n, start && !busy, RESULT_LATENCY, done)
    `VAA_ASSERT_IMPLY(a_done_source, clk, rst_n, done, $past(start && !busy, RESULT_LATENCY))
    // The flag tracks the zero vector of the matching beat and forces angle 0.
    `VAA_ASSERT_IMPLY(a_flag_zero_vec, clk, rst_n, done, flag_got == $past(zero_vec, RESULT_LATENCY))
    `VAA_ASSERT_IMPLY(a_flag_angle, clk, rst_n, done && result.undefined_angle, result.angle == '0)

endmodule

bind vector_angle_atan2_core vaa_checker u_vaa_checker (.*);
`default_nettype wire
